@@ rtl/bbc_pkg.sv @@
// Shared types, codes and bracket decode for the bracket balance checker.
// No dependencies.
package bbc_pkg;

  localparam int STACK_DEPTH_DEF = 8;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_OVERFLOW = 2'd1;
  localparam logic [1:0] ERR_MISMATCH = 2'd2;
  localparam logic [1:0] ERR_UNCLOSED = 2'd3;

  localparam logic [1:0] KIND_PAREN = 2'd0;
  localparam logic [1:0] KIND_SQUARE = 2'd1;
  localparam logic [1:0] KIND_CURLY = 2'd2;
  localparam logic [1:0] KIND_NONE = 2'd3;

  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LSQUARE = 8'h5B;
  localparam logic [7:0] CH_RSQUARE = 8'h5D;
  localparam logic [7:0] CH_LCURLY = 8'h7B;
  localparam logic [7:0] CH_RCURLY = 8'h7D;

  typedef struct packed {
    logic       accept;
    logic [7:0] symbol;
    logic       is_last;
  } step_t;

  typedef struct packed {
    logic       balanced;
    logic [1:0] error_code;
  } verdict_t;

  function automatic logic [1:0] open_kind(input logic [7:0] ch);
    logic [1:0] k;
    case (ch)
      CH_LPAREN:  k = KIND_PAREN;
      CH_LSQUARE: k = KIND_SQUARE;
      CH_LCURLY:  k = KIND_CURLY;
      default:    k = KIND_NONE;
    endcase
    return k;
  endfunction

  function automatic logic [1:0] close_kind(input logic [7:0] ch);
    logic [1:0] k;
    case (ch)
      CH_RPAREN:  k = KIND_PAREN;
      CH_RSQUARE: k = KIND_SQUARE;
      CH_RCURLY:  k = KIND_CURLY;
      default:    k = KIND_NONE;
    endcase
    return k;
  endfunction

endpackage

@@ rtl/bracket_balance_checker.sv @@
// Balanced-bracket checker, one byte per word; verdict on the last byte.
// Verdict is registered: out_valid rises in the cycle after the last byte is accepted.
// Throughput: one word per cycle unless a verdict waits for out_ready; stack top and prefetched entry cover pop.
// Reset: synchronous; empties the stack, clears the error, drops out_valid.
// Uses bbc_pkg, bbc_core, bbc_ram.
module bracket_balance_checker #(
  parameter int STACK_DEPTH = bbc_pkg::STACK_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] symbol,
  input  logic       is_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       balanced,
  output logic [1:0] error_code
);

  bbc_pkg::step_t    step;
  bbc_pkg::verdict_t verdict;

  assign in_ready     = !out_valid || out_ready;
  assign step.accept  = in_valid && in_ready;
  assign step.symbol  = symbol;
  assign step.is_last = is_last;

  bbc_core #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .verdict(verdict)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step.accept && is_last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (step.accept && is_last) begin
      balanced   <= verdict.balanced;
      error_code <= verdict.error_code;
    end
  end

endmodule

@@ rtl/bbc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bbc_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 8
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/bbc_core.sv @@
// Bracket stack engine: top entry in a register, the rest in bbc_ram,
// with the entry below the top prefetched and forwarded. Uses bbc_pkg.
module bbc_core #(
  parameter int STACK_DEPTH = bbc_pkg::STACK_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  bbc_pkg::step_t    step,
  output bbc_pkg::verdict_t verdict
);

  localparam int FW = $clog2(STACK_DEPTH + 1);
  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  logic [FW-1:0] fill, fill_next;
  logic [1:0]    err, err_next;
  logic [1:0]    tos, tos_next;
  logic          fwd_valid;
  logic [1:0]    fwd_data;
  logic [1:0]    rdata, below;
  logic          push, wr_en;
  logic [1:0]    okind, ckind, final_err;
  logic [FW-1:0] rd_fill, rd_ptr, wr_ptr;
  logic          clear;

  assign below = fwd_valid ? fwd_data : rdata;
  assign okind = bbc_pkg::open_kind(step.symbol);
  assign ckind = bbc_pkg::close_kind(step.symbol);
  assign clear = step.accept && step.is_last;

  always_comb begin
    fill_next = fill;
    err_next  = err;
    tos_next  = tos;
    push      = 1'b0;
    wr_en     = 1'b0;
    if (step.accept && err == bbc_pkg::ERR_NONE) begin
      if (okind != bbc_pkg::KIND_NONE) begin
        if (fill == FW'(STACK_DEPTH)) begin
          err_next = bbc_pkg::ERR_OVERFLOW;
        end else begin
          push      = 1'b1;
          wr_en     = (fill != '0);
          tos_next  = okind;
          fill_next = fill + FW'(1);
        end
      end else if (ckind != bbc_pkg::KIND_NONE) begin
        if (fill == '0) begin
          err_next = bbc_pkg::ERR_MISMATCH;
        end else begin
          fill_next = fill - FW'(1);
          tos_next  = below;
          if (tos != ckind) begin
            err_next = bbc_pkg::ERR_MISMATCH;
          end
        end
      end
    end
  end

  always_comb begin
    final_err = err_next;
    if (err_next == bbc_pkg::ERR_NONE && fill_next != '0) begin
      final_err = bbc_pkg::ERR_UNCLOSED;
    end
  end

  assign verdict.error_code = final_err;
  assign verdict.balanced   = (final_err == bbc_pkg::ERR_NONE);

  // old top goes to RAM on push; read address tracks the entry below the new top
  assign wr_ptr  = fill - FW'(1);
  assign rd_fill = clear ? '0 : fill_next;
  assign rd_ptr  = rd_fill - FW'(2);

  bbc_ram #(
    .WIDTH(2),
    .DEPTH(STACK_DEPTH)
  ) u_stack_ram (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_ptr[AW-1:0]),
    .wdata(tos),
    .raddr(rd_ptr[AW-1:0]),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      fill      <= '0;
      err       <= bbc_pkg::ERR_NONE;
      fwd_valid <= 1'b0;
    end else begin
      fill      <= fill_next;
      err       <= err_next;
      fwd_valid <= push;
    end
    tos <= tos_next;
    if (push) begin
      fwd_data <= tos;
    end
  end

endmodule

@@ rtl/bbc_checker.sv @@
// Port-level checks for bracket_balance_checker, bound to the top level.
// Uses bbc_pkg.
module bbc_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       is_last,
  input logic       out_valid,
  input logic       out_ready,
  input logic       balanced,
  input logic [1:0] error_code
);

  a_verdict_consistent: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (balanced == (error_code == bbc_pkg::ERR_NONE)))
    else $error("balanced disagrees with error_code");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(error_code) && $stable(balanced))
    else $error("stalled verdict changed");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !is_last && (!out_valid || out_ready) |=> !out_valid)
    else $error("verdict without a last byte");

  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && is_last |=> out_valid)
    else $error("last byte gave no verdict");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("out_valid after reset");

endmodule

bind bracket_balance_checker bbc_checker u_bbc_checker (.*);

@@ dv/bracket_balance_checker_tb.sv @@
// Self-checking testbench for bracket_balance_checker: directed strings, then random
// bracket strings under several idle/stall mixes, checked against a local bracket tracker.
// Depends on bbc_pkg and the bracket_balance_checker RTL.
`timescale 1ns / 100ps

module bracket_balance_checker_tb;

  typedef struct packed {
    logic [7:0] symbol;
    logic       fin;
  } byte_item_t;

  typedef enum int {
    STR_CLEAN,
    STR_MISMATCH,
    STR_UNCLOSED,
    STR_STRAY,
    STR_OVERFLOW
  } str_mode_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] symbol = 8'h00;
  logic       is_last = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       balanced;
  logic [1:0] error_code;

  // stimulus control, changed only at the falling edge
  int unsigned tx_idle_pct = 0;
  int unsigned rx_stall_pct = 0;
  bit          tx_hold = 1'b0;
  bit          rx_hold = 1'b0;
  bit          hold_start = 1'b0;

  byte_item_t          byte_q[$];
  byte_item_t          next_word;
  bbc_pkg::verdict_t   verdict_q[$];
  bbc_pkg::verdict_t   got_want;

  // tracker state
  logic [1:0]  kind_stack [bbc_pkg::STACK_DEPTH_DEF];
  int unsigned depth_now = 0;
  logic [1:0]  err_now = bbc_pkg::ERR_NONE;

  int unsigned items_queued = 0;
  int unsigned words_sent = 0;
  int unsigned verdicts_seen = 0;
  int unsigned err_seen [4] = '{default: 0};
  int unsigned fail_count = 0;

  bracket_balance_checker DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .symbol     (symbol),
    .is_last    (is_last),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .balanced   (balanced),
    .error_code (error_code)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic logic [7:0] bracket_char(input logic [1:0] k, input bit closing);
    logic [7:0] ch;
    case (k)
      bbc_pkg::KIND_PAREN:  ch = closing ? bbc_pkg::CH_RPAREN : bbc_pkg::CH_LPAREN;
      bbc_pkg::KIND_SQUARE: ch = closing ? bbc_pkg::CH_RSQUARE : bbc_pkg::CH_LSQUARE;
      default:              ch = closing ? bbc_pkg::CH_RCURLY : bbc_pkg::CH_LCURLY;
    endcase
    return ch;
  endfunction

  // Advance the tracker by one accepted word; queue the verdict on the last word.
  function automatic void track_bracket(input logic [7:0] ch, input logic fin);
    logic [1:0]        op;
    logic [1:0]        cl;
    bbc_pkg::verdict_t v;
    op = bbc_pkg::KIND_NONE;
    cl = bbc_pkg::KIND_NONE;
    case (ch)
      bbc_pkg::CH_LPAREN:  op = bbc_pkg::KIND_PAREN;
      bbc_pkg::CH_LSQUARE: op = bbc_pkg::KIND_SQUARE;
      bbc_pkg::CH_LCURLY:  op = bbc_pkg::KIND_CURLY;
      bbc_pkg::CH_RPAREN:  cl = bbc_pkg::KIND_PAREN;
      bbc_pkg::CH_RSQUARE: cl = bbc_pkg::KIND_SQUARE;
      bbc_pkg::CH_RCURLY:  cl = bbc_pkg::KIND_CURLY;
      default:             ;
    endcase
    if (err_now == bbc_pkg::ERR_NONE) begin
      if (op != bbc_pkg::KIND_NONE) begin
        if (depth_now >= bbc_pkg::STACK_DEPTH_DEF) begin
          err_now = bbc_pkg::ERR_OVERFLOW;
        end else begin
          kind_stack[depth_now] = op;
          depth_now++;
        end
      end else if (cl != bbc_pkg::KIND_NONE) begin
        if (depth_now == 0) begin
          err_now = bbc_pkg::ERR_MISMATCH;
        end else begin
          depth_now--;
          if (kind_stack[depth_now] != cl) err_now = bbc_pkg::ERR_MISMATCH;
        end
      end
    end
    if (fin) begin
      v.error_code = (err_now == bbc_pkg::ERR_NONE && depth_now != 0) ?
                     bbc_pkg::ERR_UNCLOSED : err_now;
      v.balanced   = (v.error_code == bbc_pkg::ERR_NONE);
      verdict_q.push_back(v);
      depth_now = 0;
      err_now   = bbc_pkg::ERR_NONE;
    end
  endfunction

  // sender
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        track_bracket(symbol, is_last);
        words_sent++;
      end
      if (byte_q.size() != 0 && !tx_hold && $urandom_range(99) >= tx_idle_pct) begin
        next_word = byte_q.pop_front();
        in_valid <= 1'b1;
        symbol   <= next_word.symbol;
        is_last  <= next_word.fin;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: unexpected verdict balanced=%0b error_code=%0d",
                   $time, balanced, error_code);
          fail_count++;
        end else begin
          got_want = verdict_q.pop_front();
          if (balanced !== got_want.balanced) begin
            $display("%0t: balanced expected %0b got %0b", $time, got_want.balanced, balanced);
            fail_count++;
          end
          if (error_code !== got_want.error_code) begin
            $display("%0t: error_code expected %0d got %0d",
                     $time, got_want.error_code, error_code);
            fail_count++;
          end
          verdicts_seen++;
          err_seen[got_want.error_code]++;
        end
      end
      out_ready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // long receiver hold-off, timed in cycles here
  initial begin
    wait (hold_start);
    rx_hold = 1'b1;
    repeat (300) @(negedge clk);
    rx_hold = 1'b0;
  end

  task automatic queue_word(input logic [7:0] b, input logic fin);
    byte_q.push_back('{symbol: b, fin: fin});
    items_queued++;
  endtask

  task automatic queue_text(input string txt);
    for (int i = 0; i < txt.len(); i++) queue_word(txt[i], i == txt.len() - 1);
  endtask

  // Mostly well-formed nesting with noise bytes; some strings broken on purpose.
  task automatic queue_string();
    logic [7:0]  txt[$];
    logic [1:0]  open_stk[$];
    str_mode_t   mode;
    int unsigned pick;
    int unsigned cap;
    int unsigned steps;
    bit          greedy;
    bit          bent;
    logic [1:0]  k;
    pick = $urandom_range(99);
    if (pick < 70)      mode = STR_CLEAN;
    else if (pick < 80) mode = STR_MISMATCH;
    else if (pick < 88) mode = STR_UNCLOSED;
    else if (pick < 94) mode = STR_STRAY;
    else                mode = STR_OVERFLOW;
    cap = (mode == STR_OVERFLOW) ?
          $urandom_range(bbc_pkg::STACK_DEPTH_DEF + 1, bbc_pkg::STACK_DEPTH_DEF + 4) :
          $urandom_range(1, bbc_pkg::STACK_DEPTH_DEF);
    greedy = (mode == STR_OVERFLOW) || ($urandom_range(3) == 0);
    steps  = $urandom_range(cap, 2 * cap + 4);
    bent   = 1'b0;
    for (int i = 0; i < steps || (open_stk.size() != 0 && mode != STR_UNCLOSED); i++) begin
      if ($urandom_range(3) == 0) txt.push_back(8'($urandom_range(255)));
      if (i < steps && open_stk.size() < cap &&
          (open_stk.size() == 0 || greedy || $urandom_range(1) == 1)) begin
        k = 2'($urandom_range(2));
        open_stk.push_back(k);
        txt.push_back(bracket_char(k, 1'b0));
        if (open_stk.size() == cap) greedy = 1'b0;
      end else if (open_stk.size() != 0) begin
        k = open_stk.pop_back();
        if (mode == STR_MISMATCH && !bent) begin
          k = 2'((k + $urandom_range(1, 2)) % 3);
          bent = 1'b1;
        end
        txt.push_back(bracket_char(k, 1'b1));
      end
    end
    if (mode == STR_UNCLOSED && open_stk.size() == 0)
      txt.push_back(bracket_char(2'($urandom_range(2)), 1'b0));
    if (mode == STR_STRAY) txt.push_back(bracket_char(2'($urandom_range(2)), 1'b1));
    if ($urandom_range(4) == 0 || txt.size() == 0) txt.push_back(8'($urandom_range(255)));
    foreach (txt[j]) queue_word(txt[j], j == txt.size() - 1);
  endtask

  task automatic wait_idle();
    do @(negedge clk); while (byte_q.size() != 0 || in_valid || verdict_q.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic run_phase(input int unsigned idle, input int unsigned stall,
                           input int unsigned words, input bit pause);
    int unsigned goal;
    @(negedge clk);
    tx_idle_pct  = idle;
    rx_stall_pct = stall;
    goal = items_queued + words;
    while (items_queued < goal) queue_string();
    if (pause) begin
      do @(negedge clk); while (byte_q.size() > words / 2);
      tx_hold = 1'b1;
      do @(negedge clk); while (in_valid || verdict_q.size() != 0);
      repeat (3) @(negedge clk);
      tx_hold = 1'b0;
    end
    wait_idle();
  endtask

  initial begin
    int unsigned goal;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(negedge clk);

    queue_text("([{}])");
    queue_text("(]");
    queue_text(")");
    queue_text("{{");
    queue_text("(((((((((");
    queue_text("]x(");
    queue_word(8'h00, 1'b0);
    queue_word(8'hFF, 1'b1);
    wait_idle();

    run_phase(0, 0, 250, 1'b0);
    run_phase(60, 0, 250, 1'b0);
    run_phase(0, 60, 250, 1'b0);
    run_phase(8, 8, 250, 1'b1);

    // long receiver hold-off while words keep coming
    @(negedge clk);
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    hold_start   = 1'b1;
    goal = items_queued + 150;
    while (items_queued < goal) queue_string();
    do @(negedge clk); while (rx_hold);
    wait_idle();
    repeat (10) @(negedge clk);

    $display("Sent %0d words, checked %0d verdicts over four idle/stall mixes",
             words_sent, verdicts_seen);
    $display("plus a long backpressure stretch; balanced %0d, overflow %0d, mismatch %0d, %s",
             err_seen[bbc_pkg::ERR_NONE], err_seen[bbc_pkg::ERR_OVERFLOW],
             err_seen[bbc_pkg::ERR_MISMATCH],
             $sformatf("unclosed %0d.", err_seen[bbc_pkg::ERR_UNCLOSED]));
    if (fail_count == 0 && verdict_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d verdicts still pending.", verdict_q.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
